>>> sv/windowed_trimmed_mean_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed trimmed mean filter
// Wraps clocked concurrent assertions in one common form.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_TRIMMED_MEAN_FILTER_TOP_ASSERT_SVH
`define WINDOWED_TRIMMED_MEAN_FILTER_TOP_ASSERT_SVH

// Checked on every rising edge once reset has been released.
`define WTM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define WTM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/wtm_pkg.sv
// ----------------------------------------------------------------------------
// Windowed trimmed mean filter package
// Shared widths, constants, types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wtm_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int WINDOW_MAX  = 16;
	localparam int ADDR_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
	localparam int DIVR_W      = ADDR_W;
	localparam int TDATA_W     = 16;
	localparam int CNT_W       = $clog2(SUM_W + 1);

	localparam logic [LEN_W-1:0] LEN_MIN          = LEN_W'(3);
	localparam logic [LEN_W-1:0] LEN_MAX          = LEN_W'(WINDOW_MAX);
	localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = LEN_W'(16);

	// Register index, taken from the word address.
	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v < LEN_MIN) begin
			r = LEN_MIN;
		end else if (v > LEN_MAX) begin
			r = LEN_MAX;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/wtm_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtm_div (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire  [wtm_pkg::SUM_W-1:0]           dividend,
	input  wire  [wtm_pkg::DIVR_W-1:0]          divisor,
	output logic [wtm_pkg::SUM_W-1:0]           quotient,
	output wtm_pkg::div_status_t                status
);
	import wtm_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W-1:0] rem_q;
	logic [SUM_W-1:0]  quot_q;
	logic [DIVR_W-1:0] divr_q;
	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, quot_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divr_q};
	assign fits  = trial >= {1'b0, divr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(SUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			divr_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			quot_q <= {quot_q[SUM_W-2:0], fits};
		end
	end

	assign quotient    = quot_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

`default_nettype wire

>>> sv/windowed_trimmed_mean_filter_top.sv
// ----------------------------------------------------------------------------
// Windowed trimmed mean filter, top level
// Olympic moving average over a circular window of converter samples.
// ----------------------------------------------------------------------------
// Each request carries one 12-bit sample and yields one trimmed mean: the sum
// of the last L samples less one minimum and one maximum, divided by L - 2.
// L is window_len clamped to 3..16. The window lives in a 16-entry memory with
// a registered read port. One request is worked on at a time: the next slot is
// found by repeated subtraction, the sample is written, the memory is scanned
// one entry a cycle and a serial divider produces the result. The first
// request after reset writes the sample into all L slots in place of the slot
// search and the single write. A new request is taken while a finished result
// still waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module windowed_trimmed_mean_filter_top (
	input  wire         clk,
	input  wire         arst_n,
	// tdata: sample [11:0], zero padding [15:12]
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,
	// tdata: trimmed_mean [11:0], zero padding [15:12]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wtm_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FILL  = 7'b0000010,
		ST_SLOT  = 7'b0000100,
		ST_WRITE = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [LEN_W-1:0]       window_len_q;
	logic [LEN_W-1:0]       len_q;
	logic [ADDR_W-1:0]      write_slot_q;
	logic                   primed_q;
	logic [LEN_W-1:0]       slot_q;
	logic [ADDR_W-1:0]      fill_cnt_q;
	logic [LEN_W-1:0]       rd_cnt_q;
	logic                   rd_vld_s1;
	logic                   acc_first_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic                   m_tvalid_q;
	logic [SAMPLE_BITS-1:0] result_q;

	logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic                   mem_re;

	logic                   cfg_wr;
	logic                   scan_end;
	logic                   div_start;
	logic [SUM_W-1:0]       numer;
	logic [SUM_W-1:0]       quotient;
	div_status_t            div_status;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_WINDOW_LEN) ? {{(32-LEN_W){1'b0}}, window_len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RESET;
		end else if (cfg_wr && (paddr[2] == REG_WINDOW_LEN)) begin
			window_len_q <= pwdata[LEN_W-1:0];
		end
	end

	// Window memory.
	assign mem_we    = (state_q == ST_FILL) || (state_q == ST_WRITE);
	assign mem_waddr = (state_q == ST_FILL) ? fill_cnt_q : slot_q[ADDR_W-1:0];
	assign mem_re    = (state_q == ST_SCAN) && (rd_cnt_q < len_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= sample_q;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_cnt_q[ADDR_W-1:0]];
		end
	end

	assign scan_end  = (state_q == ST_SCAN) && (rd_cnt_q == len_q) && !rd_vld_s1;
	assign div_start = scan_end;
	assign numer     = sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);

	wtm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (numer),
		.divisor  (DIVR_W'(len_q - LEN_W'(2))),
		.quotient (quotient),
		.status   (div_status)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= LEN_MIN;
			write_slot_q <= '0;
			primed_q     <= 1'b0;
			slot_q       <= '0;
			fill_cnt_q   <= '0;
			rd_cnt_q     <= '0;
			rd_vld_s1    <= 1'b0;
			acc_first_q  <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						len_q      <= eff_len(window_len_q);
						rd_cnt_q   <= '0;
						fill_cnt_q <= '0;
						slot_q     <= {1'b0, write_slot_q} + LEN_W'(1);
						state_q    <= primed_q ? ST_SLOT : ST_FILL;
					end
				end
				ST_FILL: begin
					fill_cnt_q <= fill_cnt_q + ADDR_W'(1);
					if ({1'b0, fill_cnt_q} == len_q - LEN_W'(1)) begin
						write_slot_q <= '0;
						primed_q     <= 1'b1;
						acc_first_q  <= 1'b1;
						state_q      <= ST_SCAN;
					end
				end
				ST_SLOT: begin
					if (slot_q >= len_q) begin
						slot_q <= slot_q - len_q;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					write_slot_q <= slot_q[ADDR_W-1:0];
					acc_first_q  <= 1'b1;
					state_q      <= ST_SCAN;
				end
				ST_SCAN: begin
					if (mem_re) begin
						rd_cnt_q <= rd_cnt_q + LEN_W'(1);
					end
					if (rd_vld_s1) begin
						acc_first_q <= 1'b0;
					end
					if (scan_end) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_tvalid) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (rd_vld_s1) begin
			if (acc_first_q) begin
				sum_q <= SUM_W'(rd_data_q);
				lo_q  <= rd_data_q;
				hi_q  <= rd_data_q;
			end else begin
				sum_q <= sum_q + SUM_W'(rd_data_q);
				if (rd_data_q < lo_q) begin
					lo_q <= rd_data_q;
				end
				if (rd_data_q > hi_q) begin
					hi_q <= rd_data_q;
				end
			end
		end
		if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
			result_q <= quotient[SAMPLE_BITS-1:0];
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_W-SAMPLE_BITS){1'b0}}, result_q};

	`include "windowed_trimmed_mean_filter_top_assert.svh"

	`WTM_ASSERT(a_no_write_in_scan, (state_q == ST_SCAN) |-> !mem_we, "memory written during scan")
	`WTM_ASSERT(a_slot_in_window, (state_q == ST_WRITE) |-> (slot_q < len_q), "write slot outside window")
	`WTM_ASSERT(a_scan_primed, (state_q == ST_SCAN) |-> primed_q, "scan before window filled")
	`WTM_ASSERT(a_div_divisor, div_start |-> (len_q >= LEN_MIN) && !div_status.busy, "bad divider start")
	`WTM_ASSERT(a_rd_cnt_bound, rd_cnt_q <= len_q, "scan counter past window")
	`WTM_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

`default_nettype wire
